// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== hdl/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// mm_pkg
// Shared widths, codes and types of the matrix multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int VAL_W         = 32;  // Q16.16 element width
  localparam int CFG_W         = 4;   // dimension register width
  localparam int CFG_IDX_W     = 2;
  localparam int KIND_W        = 2;
  localparam int IN_IDX_W      = 4;   // row/col index on the request side
  localparam int OUT_IDX_W     = 3;   // row/col index on the response side
  localparam int DEF_MAX_DIM   = 8;
  localparam int DEF_FRAC_BITS = 16;

  // transaction kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  // response status
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // per-operand control carried along the MAC pipeline
  typedef struct packed {
    logic first;  // first inner step: accumulate from zero
    logic last;   // last inner step: element complete
  } mac_tag_t;

endpackage

// ===== hdl/mm_ram.sv =====
// ----------------------------------------------------------------------------
// mm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mm_mac.sv =====
// ----------------------------------------------------------------------------
// mm_mac
// Two-stage multiply-accumulate: registered 32x32 product, then floor shift,
// add and saturate into the 32-bit accumulator.
// ----------------------------------------------------------------------------
module mm_mac #(
  parameter int FRAC_BITS = mm_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           op_valid,
  input  mm_pkg::mac_tag_t               op_tag,
  input  logic signed [mm_pkg::VAL_W-1:0] a_val,
  input  logic signed [mm_pkg::VAL_W-1:0] b_val,
  output logic signed [mm_pkg::VAL_W-1:0] acc,
  output logic                           done
);

  localparam int PROD_W = 2 * mm_pkg::VAL_W;
  localparam int SUM_W  = PROD_W + 1;

  logic                     v2;
  mm_pkg::mac_tag_t         tag2;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-mm_pkg::VAL_W:0] hi;
  logic signed [mm_pkg::VAL_W-1:0] base;
  logic signed [mm_pkg::VAL_W-1:0] acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v2   <= op_valid;
      done <= v2 && tag2.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_val * b_val;
    tag2 <= op_tag;
    if (v2) begin
      acc <= acc_next;
    end
  end

  // arithmetic shift is floor division by 2^FRAC_BITS
  always_comb begin
    shifted = prod >>> FRAC_BITS;
    base    = tag2.first ? '0 : acc;
    sum     = SUM_W'(base) + SUM_W'(shifted);
    hi      = sum[SUM_W-1:mm_pkg::VAL_W-1];
    if ((&hi) || !(|hi)) begin
      acc_next = sum[mm_pkg::VAL_W-1:0];
    end else if (sum[SUM_W-1]) begin
      acc_next = {1'b1, {(mm_pkg::VAL_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(mm_pkg::VAL_W-1){1'b1}}};
    end
  end

endmodule

// ===== hdl/matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply
// Load: written in the acceptance cycle; one per cycle while the response side is free.
// Compute: each product element takes one read pair per inner step, then RAM read,
//   multiply, accumulate and handoff; an rsp_ready stall holds the handoff.
// Reset: dimension registers go to 1, control clears; A/B stores are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

// A and B live in two RAMs addressed row * MAX_DIM + col. A compute transaction
// walks (i, j) row-major; for each element the sequencer issues one read pair per
// inner index k, the MAC pipeline folds the products, and the finished sum goes
// to the response register. Only one element is in flight, so the accumulator
// never needs forwarding. Loads are only taken in idle, so a store write never
// overlaps a compute read.
module matrix_multiply #(
  parameter int MAX_DIM   = mm_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = mm_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [mm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]           cfg_data,
  // request channel
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [mm_pkg::KIND_W-1:0]          kind,
  input  logic [mm_pkg::IN_IDX_W-1:0]        row_index,
  input  logic [mm_pkg::IN_IDX_W-1:0]        col_index,
  input  logic signed [mm_pkg::VAL_W-1:0]    element_value,
  // response channel
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic signed [mm_pkg::VAL_W-1:0]    product_value,
  output logic [mm_pkg::OUT_IDX_W-1:0]       out_row,
  output logic [mm_pkg::OUT_IDX_W-1:0]       out_col,
  output logic                               last_element,
  output logic                               status
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CFG_W  = mm_pkg::CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state;

  // dimension registers, kept as written
  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_dim;
  logic [CFG_W-1:0] cols_b;
  logic [CFG_W-1:0] dim_m;
  logic [CFG_W-1:0] dim_n;
  logic [CFG_W-1:0] dim_p;

  // sequencer
  logic [IDX_W-1:0] i_cnt;
  logic [IDX_W-1:0] j_cnt;
  logic [IDX_W-1:0] k_cnt;
  logic             i_last;
  logic             j_last;
  logic             k_last;
  logic             elem_last;

  // load path
  logic             accept;
  logic             ld_is_a;
  logic             ld_bad;
  logic [CFG_W-1:0] lim_r;
  logic [CFG_W-1:0] lim_c;
  logic [ADDR_W-1:0] ld_addr;

  // response register load
  logic             rsp_load;

  // stores
  logic              a_we;
  logic              b_we;
  logic              rd_en;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;
  logic [mm_pkg::VAL_W-1:0] a_rdata;
  logic [mm_pkg::VAL_W-1:0] b_rdata;

  // read stage tag, aligned with RAM data
  logic             v1;
  mm_pkg::mac_tag_t tag1;

  logic signed [mm_pkg::VAL_W-1:0] mac_acc;
  logic                            mac_done;

  // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return CFG_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      return CFG_W'(MAX_DIM);
    end
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(r * MAX_DIM) + ADDR_W'(c);
  endfunction

  assign dim_m = clamp_dim(rows_a);
  assign dim_n = clamp_dim(inner_dim);
  assign dim_p = clamp_dim(cols_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_W'(1);
      inner_dim <= CFG_W'(1);
      cols_b    <= CFG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        mm_pkg::REG_ROWS_A:    rows_a    <= cfg_data;
        mm_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
        mm_pkg::REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Idle takes a transaction when the response register is free or drains now;
  // an out-of-range load needs that slot.
  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;

  assign ld_is_a = (kind == mm_pkg::KIND_LOAD_A);
  assign lim_r   = ld_is_a ? dim_m : dim_n;
  assign lim_c   = ld_is_a ? dim_n : dim_p;
  assign ld_bad  = (CFG_W'(row_index) >= lim_r) || (CFG_W'(col_index) >= lim_c);
  assign ld_addr = elem_addr(row_index[IDX_W-1:0], col_index[IDX_W-1:0]);

  assign a_we = accept && (kind == mm_pkg::KIND_LOAD_A) && !ld_bad;
  assign b_we = accept && (kind == mm_pkg::KIND_LOAD_B) && !ld_bad;

  // range error in idle, or a finished element once the slot is free
  assign rsp_load = (accept && ld_bad &&
                     ((kind == mm_pkg::KIND_LOAD_A) || (kind == mm_pkg::KIND_LOAD_B))) ||
                    ((state == ST_EMIT) && (!rsp_valid || rsp_ready));

  assign i_last    = (CFG_W'(i_cnt) == dim_m - CFG_W'(1));
  assign j_last    = (CFG_W'(j_cnt) == dim_p - CFG_W'(1));
  assign k_last    = (CFG_W'(k_cnt) == dim_n - CFG_W'(1));
  assign elem_last = i_last && j_last;

  // A[i][k] and B[k][j] for the current inner step
  assign rd_en   = (state == ST_ISSUE);
  assign a_raddr = elem_addr(i_cnt, k_cnt);
  assign b_raddr = elem_addr(k_cnt, j_cnt);

  mm_ram #(
    .WIDTH (mm_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (ld_addr),
    .wdata (element_value),
    .re    (rd_en),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm_ram #(
    .WIDTH (mm_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (ld_addr),
    .wdata (element_value),
    .re    (rd_en),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    tag1.first <= (k_cnt == '0);
    tag1.last  <= k_last;
  end

  mm_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .op_valid (v1),
    .op_tag   (tag1),
    .a_val    (a_rdata),
    .b_val    (b_rdata),
    .acc      (mac_acc),
    .done     (mac_done)
  );

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      i_cnt     <= '0;
      j_cnt     <= '0;
      k_cnt     <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (kind)
              mm_pkg::KIND_LOAD_A, mm_pkg::KIND_LOAD_B: begin
                if (ld_bad) begin
                  product_value <= '0;
                  out_row       <= '0;
                  out_col       <= '0;
                  last_element  <= 1'b0;
                  status        <= mm_pkg::STATUS_RANGE;
                end
              end
              mm_pkg::KIND_COMPUTE: begin
                i_cnt <= '0;
                j_cnt <= '0;
                k_cnt <= '0;
                state <= ST_ISSUE;
              end
              default: ;  // unused kind: dropped
            endcase
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            k_cnt <= '0;
            state <= ST_DRAIN;
          end else begin
            k_cnt <= k_cnt + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            product_value <= mac_acc;
            out_row       <= mm_pkg::OUT_IDX_W'(i_cnt);
            out_col       <= mm_pkg::OUT_IDX_W'(j_cnt);
            last_element  <= elem_last;
            status        <= mm_pkg::STATUS_OK;
            if (elem_last) begin
              state <= ST_IDLE;
            end else begin
              if (j_last) begin
                j_cnt <= '0;
                i_cnt <= i_cnt + IDX_W'(1);
              end else begin
                j_cnt <= j_cnt + IDX_W'(1);
              end
              state <= ST_ISSUE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a finished sum only shows up while the sequencer is waiting for it
  `ASSERT_CLK(a_done_in_drain, clk, rst, mac_done |-> (state == ST_DRAIN))
  // store writes never coincide with a compute read in flight
  `ASSERT_NEVER(a_no_wr_during_read, clk, rst, (a_we || b_we) && (v1 || rd_en))
  // a run's final element carries ok status
  `ASSERT_CLK(a_last_ok, clk, rst,
              (rsp_valid && last_element) |-> (status == mm_pkg::STATUS_OK))
  // once the final element is handed off the sequencer is back in idle
  `ASSERT_CLK(a_last_idle, clk, rst,
              (rsp_valid && rsp_ready && last_element) |-> (state == ST_IDLE))

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix_multiply. A directed table covers reset
// dimensions, saturation, floor rounding, range errors and ignored kinds; then
// random phases set the dimensions, load A and B with random content and ask
// for products. Every returned element is checked against its table row or a local predictor.
// ----------------------------------------------------------------------------
module tb;
  import mm_pkg::*;

  localparam int MAX_DIM      = DEF_MAX_DIM;
  localparam int FRAC_BITS    = DEF_FRAC_BITS;
  localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int RAND_ITEMS   = 76;
  // margin after the last element for a trailing load or compute tail
  localparam int DRAIN_CYCLES = MAX_DIM + 12;
  localparam int IDLE_LIMIT   = 2000;
  localparam int REPORT_MAX   = 10;
  localparam int DIR_ROWS     = 24;

  // kind 3 is not decoded by the block; it must be dropped silently
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN = -Q_MAX - 1;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [IN_IDX_W-1:0]     row;
    logic [IN_IDX_W-1:0]     col;
    logic signed [VAL_W-1:0] value;
  } mm_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [OUT_IDX_W-1:0]    row;
    logic [OUT_IDX_W-1:0]    col;
    logic                    last;
    logic                    status;
  } mm_rsp_t;

  // typed = 1: exactly one response, given in want; else the predictor decides
  typedef struct packed {
    mm_req_t req;
    logic    typed;
    mm_rsp_t want;
  } dir_row_t;

  localparam mm_rsp_t RSP_RANGE = '{32'sd0, 3'd0, 3'd0, 1'b0, STATUS_RANGE};

  // Directed table, run with all dimensions at their reset value of 1.
  // A single-element product makes every expected value readable by eye.
  dir_row_t directed [DIR_ROWS] = '{
    // 1.0 * 2.0
    '{'{KIND_LOAD_A,  4'd0,  4'd0,  32'sh0001_0000}, 1'b0, '0},
    '{'{KIND_LOAD_B,  4'd0,  4'd0,  32'sh0002_0000}, 1'b0, '0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'sh0000_0000}, 1'b1,
      '{32'sh0002_0000, 3'd0, 3'd0, 1'b1, STATUS_OK}},
    // range errors on each edge of both matrices, then an unused kind
    '{'{KIND_LOAD_A,  4'd1,  4'd0,  32'sh1234_5678}, 1'b1, RSP_RANGE},
    '{'{KIND_LOAD_A,  4'd15, 4'd15, 32'shFFFF_FFFF}, 1'b1, RSP_RANGE},
    '{'{KIND_LOAD_B,  4'd0,  4'd1,  32'sh7FFF_FFFF}, 1'b1, RSP_RANGE},
    '{'{KIND_LOAD_B,  4'd15, 4'd0,  32'sh8000_0000}, 1'b1, RSP_RANGE},
    '{'{KIND_LOAD_A,  4'd0,  4'd15, 32'sh0000_0001}, 1'b1, RSP_RANGE},
    '{'{KIND_NOP,     4'd15, 4'd15, 32'shFFFF_FFFF}, 1'b0, '0},
    // rejected loads must not have touched the stores
    '{'{KIND_COMPUTE, 4'd15, 4'd15, 32'shFFFF_FFFF}, 1'b1,
      '{32'sh0002_0000, 3'd0, 3'd0, 1'b1, STATUS_OK}},
    // positive saturation
    '{'{KIND_LOAD_A,  4'd0,  4'd0,  32'sh7FFF_FFFF}, 1'b0, '0},
    '{'{KIND_LOAD_B,  4'd0,  4'd0,  32'sh7FFF_FFFF}, 1'b0, '0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'sh0000_0000}, 1'b1,
      '{32'sh7FFF_FFFF, 3'd0, 3'd0, 1'b1, STATUS_OK}},
    // negative saturation
    '{'{KIND_LOAD_A,  4'd0,  4'd0,  32'sh8000_0000}, 1'b0, '0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'sh0000_0000}, 1'b1,
      '{32'sh8000_0000, 3'd0, 3'd0, 1'b1, STATUS_OK}},
    // most negative squared
    '{'{KIND_LOAD_B,  4'd0,  4'd0,  32'sh8000_0000}, 1'b0, '0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'sh0000_0000}, 1'b1,
      '{32'sh7FFF_FFFF, 3'd0, 3'd0, 1'b1, STATUS_OK}},
    // tiny negative product rounds toward minus infinity
    '{'{KIND_LOAD_A,  4'd0,  4'd0,  32'shFFFF_FFFF}, 1'b0, '0},
    '{'{KIND_LOAD_B,  4'd0,  4'd0,  32'sh0000_0001}, 1'b0, '0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'sh0000_0000}, 1'b1,
      '{32'shFFFF_FFFF, 3'd0, 3'd0, 1'b1, STATUS_OK}},
    // mixed fractions, left to the predictor
    '{'{KIND_LOAD_A,  4'd0,  4'd0,  32'sh0001_8000}, 1'b0, '0},
    '{'{KIND_LOAD_B,  4'd0,  4'd0,  32'shFFFF_4000}, 1'b0, '0},
    '{'{KIND_COMPUTE, 4'd0,  4'd0,  32'sh0000_0000}, 1'b0, '0},
    '{'{KIND_COMPUTE, 4'd9,  4'd6,  32'sh5A5A_A5A5}, 1'b0, '0}
  };

  // DUT ports; every input has a known value from time zero
  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index     = REG_ROWS_A;
  logic [CFG_W-1:0]        cfg_data      = '0;
  logic                    req_valid     = 1'b0;
  logic                    req_ready;
  logic [KIND_W-1:0]       kind          = KIND_NOP;
  logic [IN_IDX_W-1:0]     row_index     = '0;
  logic [IN_IDX_W-1:0]     col_index     = '0;
  logic signed [VAL_W-1:0] element_value = '0;
  logic                    rsp_valid;
  logic                    rsp_ready     = 1'b0;
  logic signed [VAL_W-1:0] product_value;
  logic [OUT_IDX_W-1:0]    out_row;
  logic [OUT_IDX_W-1:0]    out_col;
  logic                    last_element;
  logic                    status;

  // predictor state: dimension registers as written, and both stores
  logic [CFG_W-1:0]        dim_reg [3] = '{4'd1, 4'd1, 4'd1};
  logic signed [VAL_W-1:0] a_elems [STORE_DEPTH];
  logic signed [VAL_W-1:0] b_elems [STORE_DEPTH];
  // entries written since reset; a compute never reads anything else
  bit                      a_loaded [STORE_DEPTH];
  bit                      b_loaded [STORE_DEPTH];

  mm_rsp_t expected_elements [$];  // in flight, oldest first
  mm_rsp_t predicted [$];          // output of one predictor call
  int      mismatches  = 0;
  int      idle_cycles = 0;
  int      rand_items  = 0;
  int      stall_left  = 0;
  bit      no_idle     = 1'b0;     // phase without any gaps on either side

  matrix_multiply i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register value 0 acts as 1, anything above MAX_DIM as MAX_DIM
  function automatic int dim_active(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Mostly zero, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Q16.16 content: extremes, small magnitudes and raw random bits
  function automatic logic signed [VAL_W-1:0] rand_element();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5, 6: return VAL_W'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random load of A or B, inside the active dimensions or outside them.
  function automatic mm_req_t rand_load(input bit in_range);
    mm_req_t r;
    int      lim_r;
    int      lim_c;
    r.kind  = $urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A;
    lim_r   = dim_active(dim_reg[(r.kind == KIND_LOAD_A) ? REG_ROWS_A : REG_INNER_DIM]);
    lim_c   = dim_active(dim_reg[(r.kind == KIND_LOAD_A) ? REG_INNER_DIM : REG_COLS_B]);
    r.value = rand_element();
    if (in_range) begin
      r.row = IN_IDX_W'($urandom_range(0, lim_r - 1));
      r.col = IN_IDX_W'($urandom_range(0, lim_c - 1));
    end else if ($urandom_range(0, 1)) begin
      r.row = IN_IDX_W'($urandom_range(lim_r, 15));
      r.col = IN_IDX_W'($urandom_range(0, 15));
    end else begin
      r.row = IN_IDX_W'($urandom_range(0, 15));
      r.col = IN_IDX_W'($urandom_range(lim_c, 15));
    end
    return r;
  endfunction

  // Predictor: updates the stores on a load and fills `predicted` with the
  // responses one request causes.
  function automatic void predict_products(input mm_req_t r);
    int      m;
    int      n;
    int      p;
    int      lim_r;
    int      lim_c;
    longint  acc;
    longint  prod;
    mm_rsp_t e;
    m = dim_active(dim_reg[REG_ROWS_A]);
    n = dim_active(dim_reg[REG_INNER_DIM]);
    p = dim_active(dim_reg[REG_COLS_B]);
    case (r.kind)
      KIND_LOAD_A, KIND_LOAD_B: begin
        lim_r = (r.kind == KIND_LOAD_A) ? m : n;
        lim_c = (r.kind == KIND_LOAD_A) ? n : p;
        if (r.row >= lim_r || r.col >= lim_c) begin
          predicted.push_back(RSP_RANGE);
        end else if (r.kind == KIND_LOAD_A) begin
          a_elems[int'(r.row) * MAX_DIM + int'(r.col)] = r.value;
        end else begin
          b_elems[int'(r.row) * MAX_DIM + int'(r.col)] = r.value;
        end
      end
      KIND_COMPUTE: begin
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < p; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++) begin
              prod = longint'(a_elems[i * MAX_DIM + k]) * longint'(b_elems[k * MAX_DIM + j]);
              // arithmetic shift of a signed product = floor division
              acc = acc + (prod >>> FRAC_BITS);
              if (acc > Q_MAX) acc = Q_MAX;
              else if (acc < Q_MIN) acc = Q_MIN;
            end
            e.value  = acc[VAL_W-1:0];
            e.row    = OUT_IDX_W'(i);
            e.col    = OUT_IDX_W'(j);
            e.last   = (i == m - 1) && (j == p - 1);
            e.status = STATUS_OK;
            predicted.push_back(e);
          end
        end
      end
      default: ;  // unused kind: dropped
    endcase
  endfunction

  // Present one request and wait for its transaction. Called and returns at a
  // rising edge; req_valid stays high on return so back-to-back requests never
  // see it dropped and raised in the same step.
  task automatic send_req(input mm_req_t r, input bit typed, input mm_rsp_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid     <= 1'b1;
    kind          <= r.kind;
    row_index     <= r.row;
    col_index     <= r.col;
    element_value <= r.value;
    // inputs and outputs are settled at the falling edge; the transaction
    // happens at the next rising edge when ready was seen high
    do @(negedge clk); while (!req_ready);
    @(posedge clk);
    predicted.delete();
    predict_products(r);
    if (typed) expected_elements.push_back(want);
    else foreach (predicted[i]) expected_elements.push_back(predicted[i]);
  endtask

  // Drain: all responses back, then enough cycles for a trailing load or a
  // compute tail to settle before the registers are touched.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_elements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(input logic [CFG_W-1:0] rows, inner, cols);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_W-1:0]     val [3];
    idx = '{REG_ROWS_A, REG_INNER_DIM, REG_COLS_B};
    val = '{rows, inner, cols};
    for (int i = 0; i < 3; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      dim_reg[idx[i]] = val[i];
    end
    cfg_write <= 1'b0;
  endtask

  // Response side back-pressure: random stalls, none in quiet phases.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Scoreboard and watchdog, sampled mid-cycle where nothing moves.
  always @(negedge clk) begin : rsp_check
    mm_rsp_t got;
    mm_rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        got = '{product_value, out_row, out_col, last_element, status};
        if (expected_elements.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected element: value %h row %0d col %0d last %b status %b",
                     got.value, got.row, got.col, got.last, got.status);
          mismatches++;
        end else begin
          want = expected_elements.pop_front();
          if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
              got.last !== want.last || got.status !== want.status) begin
            if (mismatches < REPORT_MAX) begin
              $display("mismatch: expected value %h row %0d col %0d last %b status %b",
                       want.value, want.row, want.col, want.last, want.status);
              $display("          actual   value %h row %0d col %0d last %b status %b",
                       got.value, got.row, got.col, got.last, got.status);
            end
            mismatches++;
          end
        end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    mm_req_t          batch [$];
    mm_req_t          r;
    logic [CFG_W-1:0] fixed_dims [4][3];
    logic [CFG_W-1:0] d [3];
    int               m;
    int               n;
    int               p;
    int               j;
    int               phase;

    // extremes first: all-zero registers (act as 1), widest product
    // (64 elements), longest inner sum, and over-range values
    fixed_dims = '{'{4'd0, 4'd0, 4'd0}, '{4'd15, 4'd1, 4'd15},
                   '{4'd1, 4'd15, 4'd1}, '{4'd9, 4'd2, 4'd8}};
    foreach (a_elems[i]) begin
      a_elems[i]  = '0;
      b_elems[i]  = '0;
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_req(directed[i].req, directed[i].typed, directed[i].want);
    a_loaded[0] = 1'b1;
    b_loaded[0] = 1'b1;
    wait_idle();

    // Random phases: new dimensions, fill whatever the product will read,
    // sprinkle overwrites and junk, shuffle, then compute (sometimes twice).
    phase = 0;
    while (phase < 4 || rand_items < RAND_ITEMS) begin
      if (phase < 4) begin
        d = fixed_dims[phase];
      end else begin
        foreach (d[i])
          d[i] = ($urandom_range(0, 9) < 7) ? CFG_W'($urandom_range(1, 4))
                                            : CFG_W'($urandom_range(0, 15));
      end
      write_dims(d[0], d[1], d[2]);
      no_idle = ($urandom_range(0, 3) == 0);
      m = dim_active(d[0]);
      n = dim_active(d[1]);
      p = dim_active(d[2]);

      batch.delete();
      for (int i = 0; i < m; i++) begin
        for (int k = 0; k < n; k++) begin
          if (!a_loaded[i * MAX_DIM + k]) begin
            a_loaded[i * MAX_DIM + k] = 1'b1;
            batch.push_back('{KIND_LOAD_A, IN_IDX_W'(i), IN_IDX_W'(k), rand_element()});
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        for (int jj = 0; jj < p; jj++) begin
          if (!b_loaded[k * MAX_DIM + jj]) begin
            b_loaded[k * MAX_DIM + jj] = 1'b1;
            batch.push_back('{KIND_LOAD_B, IN_IDX_W'(k), IN_IDX_W'(jj), rand_element()});
          end
        end
      end
      repeat ($urandom_range(0, 3)) batch.push_back(rand_load(1'b1));
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 2) == 0)
          batch.push_back('{KIND_NOP, IN_IDX_W'($urandom_range(0, 15)),
                            IN_IDX_W'($urandom_range(0, 15)), rand_element()});
        else
          batch.push_back(rand_load(1'b0));
      end
      // in-range entries are all in this batch or written earlier, so any
      // order is safe for the compute that follows
      for (int i = batch.size() - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        r        = batch[i];
        batch[i] = batch[j];
        batch[j] = r;
      end
      batch.push_back('{KIND_COMPUTE, IN_IDX_W'($urandom_range(0, 15)),
                        IN_IDX_W'($urandom_range(0, 15)), rand_element()});
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 3)) batch.push_back(rand_load(1'b1));
        batch.push_back('{KIND_COMPUTE, '0, '0, '0});
      end

      foreach (batch[i]) begin
        send_req(batch[i], 1'b0, '0);
        if (batch[i].kind != KIND_NOP) rand_items++;
      end
      wait_idle();
      phase++;
    end

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mm_pkg.sv
hdl/mm_ram.sv
hdl/mm_mac.sv
hdl/matrix_multiply.sv
bench/tb.sv
